FILE: design/iqcf_pkg.sv
`timescale 1ns / 1ps

package iqcf_pkg;

    localparam int LEVEL_W = 16;
    localparam int IMPR_W  = 17;
    localparam int CFG_W   = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // register map, index = paddr[2]
    localparam logic REG_INIT_I = 1'b0;
    localparam logic REG_INIT_Q = 1'b1;

    localparam logic [CFG_W-1:0] INIT_CODE_RST = 8'd128;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_MEAS  = 1'b1;

    localparam logic [3:0] COARSE_STEP   = 4'd10;
    localparam logic [3:0] WIDE_RADIUS   = 4'd15;
    localparam logic [3:0] MID_RADIUS    = 4'd3;
    localparam logic [3:0] NARROW_RADIUS = 4'd1;
    localparam logic [2:0] SEQ_LAST_PASS = 3'd2;

    function automatic logic [3:0] radius_of(input logic [2:0] pass);
        logic [3:0] r;
        if (pass == 3'd1) begin
            r = WIDE_RADIUS;
        end else if (pass == 3'd2 || pass == 3'd3) begin
            r = MID_RADIUS;
        end else begin
            r = NARROW_RADIUS;
        end
        return r;
    endfunction

endpackage

FILE: design/iqcf_if.sv
`timescale 1ns / 1ps

interface iqcf_in_if;
    import iqcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [LEVEL_W-1:0] level;

    modport source (output valid, cmd, level, input ready);
    modport sink   (input valid, cmd, level, output ready);
endinterface

interface iqcf_out_if #(
    parameter int CODE_BITS = 8
);
    import iqcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CODE_BITS-1:0]      trial_i;
    logic [CODE_BITS-1:0]      trial_q;
    logic                      done_res;
    logic [CODE_BITS-1:0]      best_i;
    logic [CODE_BITS-1:0]      best_q;
    logic signed [LEVEL_W-1:0] best_level;
    logic signed [IMPR_W-1:0]  improvement;

    modport source (output valid, trial_i, trial_q, done_res, best_i, best_q, best_level,
                    improvement, input ready);
    modport sink   (input valid, trial_i, trial_q, done_res, best_i, best_q, best_level,
                    improvement, output ready);
endinterface

FILE: design/iq_offset_coarse_fine_search.sv
`timescale 1ns / 1ps

// I/Q offset correction search: coarse sweep, then narrowing windows around the best codes.
// Input channel i_in: cmd = start (0) or measurement (1) with the measured leakage level.
// A start returns the initial codes to measure; each measurement returns the next I/Q
// trial pair, or a done item carrying the best codes, best level and improvement.
// A measurement while idle is consumed and produces no item.
// Out-of-range trial codes are never issued: the search windows are clamped to the code range
// when a pass begins, so no measurement has to skip over out-of-range positions.
// The result is registered and appears on o_out in the cycle after input acceptance.
// Throughput: one item per cycle unless o_out stalls; the sequencer state update is a single registered step.
// The output register holds a result while o_out.ready is low and i_in.ready drops only then;
// an item is accepted whenever the output register is empty or being drained.
// APB port: initial_i_code at 0x0, initial_q_code at 0x4 (reset 128), sampled at each start.
// Reset (synchronous, active low) leaves the block idle with both registers at 128.
module iq_offset_coarse_fine_search #(
    parameter int CODE_BITS  = 8,
    parameter int PASS_COUNT = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    iqcf_in_if.sink                       i_in,
    iqcf_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iqcf_pkg::APB_AW-1:0]   paddr,
    input  logic [iqcf_pkg::APB_DW-1:0]   pwdata,
    output logic [iqcf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import iqcf_pkg::*;

    localparam int CW    = CODE_BITS;
    localparam int XW    = CODE_BITS + 1;
    localparam int EXT_W = (CODE_BITS > CFG_W) ? CODE_BITS : CFG_W;
    localparam int PW    = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;
    localparam logic [CW-1:0] CODE_MAX = {CW{1'b1}};
    localparam logic [EXT_W-1:0] RST_EXT = EXT_W'(INIT_CODE_RST);
    localparam logic [CW-1:0] RST_CODE = RST_EXT[CW-1:0];

    typedef enum logic [1:0] {
        PART_I,
        PART_Q,
        PART_GRID
    } t_part;

    function automatic logic [CW-1:0] clamp_lo(input logic [CW-1:0] a, input logic [3:0] r);
        logic [XW-1:0] ax;
        logic [XW-1:0] rx;
        logic [XW-1:0] d;
        ax = {1'b0, a};
        rx = XW'(r);
        d  = ax - rx;
        return (ax < rx) ? '0 : d[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] clamp_hi(input logic [CW-1:0] a, input logic [3:0] r);
        logic [XW-1:0] s;
        s = {1'b0, a} + XW'(r);
        return (s > {1'b0, CODE_MAX}) ? CODE_MAX : s[CW-1:0];
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_init_i;
    logic [CFG_W-1:0] r_init_q;
    logic             cfg_wr;
    logic [EXT_W-1:0] init_i_ext;
    logic [EXT_W-1:0] init_q_ext;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_INIT_Q) ? APB_DW'(r_init_q) : APB_DW'(r_init_i);
    assign init_i_ext = EXT_W'(r_init_i);
    assign init_q_ext = EXT_W'(r_init_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_i <= INIT_CODE_RST;
            r_init_q <= INIT_CODE_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_INIT_Q) begin
                r_init_q <= pwdata[CFG_W-1:0];
            end else begin
                r_init_i <= pwdata[CFG_W-1:0];
            end
        end
    end

    // sequencer state
    logic                      r_running, n_running;
    logic                      r_await, n_await;
    logic [PW-1:0]             r_pass, n_pass;
    t_part                     r_part, n_part;
    logic [CW-1:0]             r_cur_i, n_cur_i;
    logic [CW-1:0]             r_cur_q, n_cur_q;
    logic [CW-1:0]             r_hi_i, n_hi_i;
    logic [CW-1:0]             r_lo_q, n_lo_q;
    logic [CW-1:0]             r_hi_q, n_hi_q;
    logic [CW-1:0]             r_best_i, n_best_i;
    logic [CW-1:0]             r_best_q, n_best_q;
    logic signed [LEVEL_W-1:0] r_lowest, n_lowest;
    logic signed [LEVEL_W-1:0] r_initial, n_initial;

    // output register
    logic                      r_out_valid, n_out_valid;
    logic [CW-1:0]             r_out_ti, n_out_ti;
    logic [CW-1:0]             r_out_tq, n_out_tq;
    logic                      r_out_done, n_out_done;
    logic [CW-1:0]             r_out_bi, n_out_bi;
    logic [CW-1:0]             r_out_bq, n_out_bq;
    logic signed [LEVEL_W-1:0] r_out_lvl, n_out_lvl;
    logic signed [IMPR_W-1:0]  r_out_impr, n_out_impr;

    logic          accept;
    logic          take;
    logic [CW-1:0] nb_i;
    logic [CW-1:0] nb_q;
    logic [PW-1:0] bp_pass;
    logic [3:0]    bp_rad;
    logic          bp_first;
    logic          bp_grid;
    logic [CW-1:0] bp_lo_i;
    logic [CW-1:0] bp_hi_i;
    logic [CW-1:0] bp_lo_q;
    logic [CW-1:0] bp_hi_q;
    logic [3:0]    step;
    logic [XW-1:0] sum_i;
    logic [XW-1:0] sum_q;
    logic [XW-1:0] inc_i;
    logic [XW-1:0] inc_q;
    logic          last_pass;
    logic          pass_end;
    logic          done;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // a better level only counts once the initial level is known
    assign take = !r_await && (i_in.level < r_lowest);
    assign nb_i = take ? r_cur_i : r_best_i;
    assign nb_q = take ? r_cur_q : r_best_q;

    // next pass window, built around the best codes after this measurement
    assign bp_pass  = r_await ? '0 : r_pass + PW'(1);
    assign bp_first = (bp_pass == '0);
    assign bp_rad   = radius_of(3'(bp_pass));
    assign bp_grid  = 3'(bp_pass) > SEQ_LAST_PASS;
    assign bp_lo_i  = bp_first ? '0 : clamp_lo(nb_i, bp_rad);
    assign bp_hi_i  = bp_first ? CODE_MAX : clamp_hi(nb_i, bp_rad);
    assign bp_lo_q  = bp_first ? '0 : clamp_lo(nb_q, bp_rad);
    assign bp_hi_q  = bp_first ? CODE_MAX : clamp_hi(nb_q, bp_rad);

    assign step      = (r_pass == '0) ? COARSE_STEP : 4'd1;
    assign sum_i     = {1'b0, r_cur_i} + XW'(step);
    assign sum_q     = {1'b0, r_cur_q} + XW'(step);
    assign inc_i     = {1'b0, r_cur_i} + XW'(1);
    assign inc_q     = {1'b0, r_cur_q} + XW'(1);
    assign last_pass = (r_pass == PW'(PASS_COUNT - 1));

    always_comb begin
        n_running  = r_running;
        n_await    = r_await;
        n_pass     = r_pass;
        n_part     = r_part;
        n_cur_i    = r_cur_i;
        n_cur_q    = r_cur_q;
        n_hi_i     = r_hi_i;
        n_lo_q     = r_lo_q;
        n_hi_q     = r_hi_q;
        n_best_i   = r_best_i;
        n_best_q   = r_best_q;
        n_lowest   = r_lowest;
        n_initial  = r_initial;
        n_out_valid = r_out_valid && !o_out.ready;
        pass_end   = 1'b0;
        done       = 1'b0;

        if (accept) begin
            if (i_in.cmd == CMD_START) begin
                n_best_i    = init_i_ext[CW-1:0];
                n_best_q    = init_q_ext[CW-1:0];
                n_cur_i     = init_i_ext[CW-1:0];
                n_cur_q     = init_q_ext[CW-1:0];
                n_pass      = '0;
                n_part      = PART_I;
                n_lowest    = '0;
                n_initial   = '0;
                n_await     = 1'b1;
                n_running   = 1'b1;
                n_out_valid = 1'b1;
            end else if (r_running) begin
                n_out_valid = 1'b1;
                if (r_await) begin
                    n_await   = 1'b0;
                    n_lowest  = i_in.level;
                    n_initial = i_in.level;
                    pass_end  = 1'b1;
                end else begin
                    n_best_i = nb_i;
                    n_best_q = nb_q;
                    if (take) begin
                        n_lowest = i_in.level;
                    end
                    unique case (r_part)
                        PART_I: begin
                            if (sum_i > {1'b0, r_hi_i}) begin
                                n_part  = PART_Q;
                                n_cur_i = nb_i;
                                n_cur_q = r_lo_q;
                            end else begin
                                n_cur_i = sum_i[CW-1:0];
                            end
                        end
                        PART_Q: begin
                            if (sum_q <= {1'b0, r_hi_q}) begin
                                n_cur_q = sum_q[CW-1:0];
                            end else begin
                                pass_end = 1'b1;
                            end
                        end
                        PART_GRID: begin
                            if (inc_q <= {1'b0, r_hi_q}) begin
                                n_cur_q = inc_q[CW-1:0];
                            end else if (inc_i <= {1'b0, r_hi_i}) begin
                                n_cur_q = r_lo_q;
                                n_cur_i = inc_i[CW-1:0];
                            end else begin
                                pass_end = 1'b1;
                            end
                        end
                        default: begin
                            pass_end = 1'b1;
                        end
                    endcase
                    if (pass_end && last_pass) begin
                        done = 1'b1;
                    end
                end
                if (pass_end && !done) begin
                    n_pass  = bp_pass;
                    n_hi_i  = bp_hi_i;
                    n_lo_q  = bp_lo_q;
                    n_hi_q  = bp_hi_q;
                    n_cur_i = bp_lo_i;
                    n_part  = bp_grid ? PART_GRID : PART_I;
                    n_cur_q = bp_grid ? bp_lo_q : nb_q;
                end
                if (done) begin
                    n_running = 1'b0;
                end
            end
        end

        // result fields, only loaded when a new item is produced
        n_out_ti   = r_out_ti;
        n_out_tq   = r_out_tq;
        n_out_done = r_out_done;
        n_out_bi   = r_out_bi;
        n_out_bq   = r_out_bq;
        n_out_lvl  = r_out_lvl;
        n_out_impr = r_out_impr;
        if (accept && (i_in.cmd == CMD_START || r_running)) begin
            n_out_ti   = done ? n_best_i : n_cur_i;
            n_out_tq   = done ? n_best_q : n_cur_q;
            n_out_done = done;
            n_out_bi   = n_best_i;
            n_out_bq   = n_best_q;
            n_out_lvl  = n_lowest;
            n_out_impr = IMPR_W'(n_initial) - IMPR_W'(n_lowest);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_await     <= 1'b0;
            r_pass      <= '0;
            r_part      <= PART_I;
            r_cur_i     <= '0;
            r_cur_q     <= '0;
            r_hi_i      <= '0;
            r_lo_q      <= '0;
            r_hi_q      <= '0;
            r_best_i    <= RST_CODE;
            r_best_q    <= RST_CODE;
            r_lowest    <= '0;
            r_initial   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_await     <= n_await;
            r_pass      <= n_pass;
            r_part      <= n_part;
            r_cur_i     <= n_cur_i;
            r_cur_q     <= n_cur_q;
            r_hi_i      <= n_hi_i;
            r_lo_q      <= n_lo_q;
            r_hi_q      <= n_hi_q;
            r_best_i    <= n_best_i;
            r_best_q    <= n_best_q;
            r_lowest    <= n_lowest;
            r_initial   <= n_initial;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ti   <= n_out_ti;
        r_out_tq   <= n_out_tq;
        r_out_done <= n_out_done;
        r_out_bi   <= n_out_bi;
        r_out_bq   <= n_out_bq;
        r_out_lvl  <= n_out_lvl;
        r_out_impr <= n_out_impr;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.trial_i     = r_out_ti;
    assign o_out.trial_q     = r_out_tq;
    assign o_out.done_res    = r_out_done;
    assign o_out.best_i      = r_out_bi;
    assign o_out.best_q      = r_out_bq;
    assign o_out.best_level  = r_out_lvl;
    assign o_out.improvement = r_out_impr;

endmodule

FILE: test/iqcf_search_checker.sv
`timescale 1ns / 1ps

module iqcf_search_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    iqcf_in_if                            i_item_bus,
    iqcf_out_if                           i_res_bus,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [iqcf_pkg::APB_AW-1:0]   i_paddr,
    input  logic [iqcf_pkg::APB_DW-1:0]   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import iqcf_pkg::*;

    localparam int CODE_W   = 8;
    localparam int CODE_TOP = (1 << CODE_W) - 1;
    localparam int PASSES   = 6;
    localparam int MAX_REPORTS = 100;

    typedef enum int {SWEEP_I, SWEEP_Q, SWEEP_GRID} t_sweep;

    typedef struct {
        logic [CODE_W-1:0]         ti;
        logic [CODE_W-1:0]         tq;
        logic                      done;
        logic [CODE_W-1:0]         bi;
        logic [CODE_W-1:0]         bq;
        logic signed [LEVEL_W-1:0] lvl;
        logic signed [IMPR_W-1:0]  impr;
    } t_trial_res;

    t_trial_res pending_trials[$];
    int fails = 0;

    // configuration copy and search state
    logic [CFG_W-1:0] cfg_init_i, cfg_init_q;
    int     pass_no;
    t_sweep part;
    int     cur_i, cur_q, anc_i, anc_q, best_i, best_q, low_lvl, init_lvl;
    bit     wait_init, busy;

    assign o_fail_count = fails;

    function automatic int win_radius(input int p);
        if (p == 1) return int'(WIDE_RADIUS);
        if (p == 2 || p == 3) return int'(MID_RADIUS);
        return int'(NARROW_RADIUS);
    endfunction

    function automatic int win_lo(input int p, input int a);
        return (p == 0) ? 0 : a - win_radius(p);
    endfunction

    function automatic int win_hi(input int p, input int a);
        return (p == 0) ? CODE_TOP : a + win_radius(p);
    endfunction

    function automatic int win_step(input int p);
        return (p == 0) ? int'(COARSE_STEP) : 1;
    endfunction

    function automatic void open_pass(input int p);
        pass_no = p;
        anc_i   = best_i;
        anc_q   = best_q;
        cur_i   = win_lo(p, anc_i);
        if (p <= int'(SEQ_LAST_PASS)) begin
            part  = SWEEP_I;
            cur_q = best_q;
        end else begin
            part  = SWEEP_GRID;
            cur_q = win_lo(p, anc_q);
        end
    endfunction

    // step to the next trial position; 0 once the last pass is exhausted
    function automatic bit move_on();
        int p;
        p = pass_no;
        if (part == SWEEP_I) begin
            cur_i += win_step(p);
            if (cur_i > win_hi(p, anc_i)) begin
                part  = SWEEP_Q;
                cur_i = best_i;
                cur_q = win_lo(p, anc_q);
            end
            return 1'b1;
        end
        if (part == SWEEP_Q) begin
            cur_q += win_step(p);
            if (cur_q <= win_hi(p, anc_q)) return 1'b1;
        end else begin
            cur_q += 1;
            if (cur_q <= win_hi(p, anc_q)) return 1'b1;
            cur_q = win_lo(p, anc_q);
            cur_i += 1;
            if (cur_i <= win_hi(p, anc_i)) return 1'b1;
        end
        if (p + 1 >= PASSES) return 1'b0;
        open_pass(p + 1);
        return 1'b1;
    endfunction

    function automatic bit code_ok(input int c);
        return c >= 0 && c <= CODE_TOP;
    endfunction

    function automatic bit skip_out_of_range();
        while (!code_ok(cur_i) || !code_ok(cur_q)) begin
            if (!move_on()) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_trial_res make_res(input int ti, input int tq, input bit done);
        t_trial_res r;
        r.ti   = CODE_W'(ti);
        r.tq   = CODE_W'(tq);
        r.done = done;
        r.bi   = CODE_W'(best_i);
        r.bq   = CODE_W'(best_q);
        r.lvl  = LEVEL_W'(low_lvl);
        r.impr = IMPR_W'(init_lvl - low_lvl);
        return r;
    endfunction

    // returns 1 when the item produces a result
    function automatic bit next_trial(input logic cmd, input logic signed [LEVEL_W-1:0] lv,
                                      output t_trial_res r);
        int meas;
        bit more;
        meas = lv;
        if (cmd == CMD_START) begin
            best_i    = cfg_init_i;
            best_q    = cfg_init_q;
            anc_i     = best_i;
            anc_q     = best_q;
            pass_no   = 0;
            part      = SWEEP_I;
            cur_i     = best_i;
            cur_q     = best_q;
            low_lvl   = 0;
            init_lvl  = 0;
            wait_init = 1'b1;
            busy      = 1'b1;
            r = make_res(best_i, best_q, 1'b0);
            return 1'b1;
        end
        if (!busy) return 1'b0;
        more = 1'b1;
        if (wait_init) begin
            wait_init = 1'b0;
            low_lvl   = meas;
            init_lvl  = meas;
            open_pass(0);
        end else begin
            if (meas < low_lvl) begin
                low_lvl = meas;
                best_i  = cur_i;
                best_q  = cur_q;
            end
            more = move_on();
        end
        if (more) more = skip_out_of_range();
        if (!more) begin
            busy = 1'b0;
            r = make_res(best_i, best_q, 1'b1);
        end else begin
            r = make_res(cur_i, cur_q, 1'b0);
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string nm, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            if (fails < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_trial_res want, got;
        if (!i_rst_n) begin
            cfg_init_i = INIT_CODE_RST;
            cfg_init_q = INIT_CODE_RST;
            pass_no    = 0;
            part       = SWEEP_I;
            cur_i      = 0;
            cur_q      = 0;
            anc_i      = 128;
            anc_q      = 128;
            best_i     = 128;
            best_q     = 128;
            low_lvl    = 0;
            init_lvl   = 0;
            wait_init  = 1'b0;
            busy       = 1'b0;
            pending_trials.delete();
        end else begin
            if (i_item_bus.valid && i_item_bus.ready) begin
                if (next_trial(i_item_bus.cmd, i_item_bus.level, want))
                    pending_trials = {pending_trials, want};
            end
            if (i_res_bus.valid && i_res_bus.ready) begin
                got.ti   = i_res_bus.trial_i;
                got.tq   = i_res_bus.trial_q;
                got.done = i_res_bus.done_res;
                got.bi   = i_res_bus.best_i;
                got.bq   = i_res_bus.best_q;
                got.lvl  = i_res_bus.best_level;
                got.impr = i_res_bus.improvement;
                if (pending_trials.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got trial %0d/%0d",
                                 $time, got.ti, got.tq);
                    fails++;
                end else begin
                    want = pending_trials.pop_front();
                    check_field("trial_i", want.ti, got.ti);
                    check_field("trial_q", want.tq, got.tq);
                    check_field("done_res", want.done, got.done);
                    check_field("best_i", want.bi, got.bi);
                    check_field("best_q", want.bq, got.bq);
                    check_field("best_level", want.lvl, got.lvl);
                    check_field("improvement", want.impr, got.impr);
                end
            end
            // a start on the same edge still sees the old register value
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_INIT_I: cfg_init_i = i_pwdata[CFG_W-1:0];
                    REG_INIT_Q: cfg_init_q = i_pwdata[CFG_W-1:0];
                endcase
            end
        end
        o_pending <= pending_trials.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import iqcf_pkg::*;

    localparam int TARGET_RESULTS = 1700;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic sink_ready = 1'b0;
    int   stall_left = 0;
    bit   no_gaps    = 1'b0;

    int         fail_count;
    int         pending_count;
    int         outs_seen = 0;
    logic [7:0] seen_ti = '0;
    logic [7:0] seen_tq = '0;
    logic       seen_done = 1'b0;

    iqcf_in_if  in_if ();
    iqcf_out_if #(.CODE_BITS(8)) out_if ();

    assign out_if.ready = sink_ready;

    iq_offset_coarse_fine_search #(
        .CODE_BITS  (8),
        .PASS_COUNT (6)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    iqcf_search_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_bus   (in_if),
        .i_res_bus    (out_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random stalls, and a record of the latest trial for closed-loop searches
    always @(posedge i_clk) begin : drain
        int r;
        if (out_if.valid && sink_ready) begin
            outs_seen <= outs_seen + 1;
            seen_ti   <= out_if.trial_i;
            seen_tq   <= out_if.trial_q;
            seen_done <= out_if.done_res;
        end
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!no_gaps) begin
                if (r < 10) stall_left <= $urandom_range(1, 3);
                else if (r < 13) stall_left <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        if (r == 2) return 1;
        if (r == 3) return 254;
        return $urandom_range(0, 255);
    endfunction

    // synthetic leakage: a bowl around the target codes plus a little noise and rare extreme values
    function automatic logic signed [LEVEL_W-1:0] leak_at(input int ti, input int tq,
                                                          input int gi, input int gq);
        int d, v, r;
        d = ((ti > gi) ? ti - gi : gi - ti) + ((tq > gq) ? tq - gq : gq - tq);
        v = d * 60 - 16000 + $urandom_range(0, 63);
        r = $urandom_range(0, 199);
        if (r == 0) v = -32768;
        else if (r == 1) v = 32767;
        return LEVEL_W'(v);
    endfunction

    task automatic send_item(input logic c, input logic signed [LEVEL_W-1:0] lv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= c;
        in_if.level <= lv;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_result(input int n);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (outs_seen < n);
    endtask

    // nothing in flight: all results drained, plus a margin for ignored items
    task automatic settle_idle();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // each measurement answers the trial the block just asked for
    task automatic closed_search(input int gi, input int gq);
        int n;
        n = outs_seen + 1;
        send_item(CMD_START, LEVEL_W'($urandom));
        wait_result(n);
        while (!seen_done) begin
            n = outs_seen + 1;
            send_item(CMD_MEAS, leak_at(seen_ti, seen_tq, gi, gq));
            wait_result(n);
        end
    endtask

    // free-running: may end early, overrun into idle, or be cut by the next start
    task automatic open_burst(input int n);
        send_item(CMD_START, LEVEL_W'($urandom));
        repeat (n) send_item(CMD_MEAS, LEVEL_W'($urandom));
    endtask

    initial begin : stim
        int k, kind;
        in_if.valid <= 1'b0;
        in_if.cmd   <= CMD_START;
        in_if.level <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle measurement, extremes, restart while running
        send_item(CMD_MEAS, 16'sh7FFF);
        send_item(CMD_START, 16'sh0000);
        send_item(CMD_MEAS, 16'sh0000);
        send_item(CMD_MEAS, -16'sh8000);
        send_item(CMD_MEAS, 16'sh7FFF);
        send_item(CMD_MEAS, 16'sh0001);
        send_item(CMD_MEAS, -16'sh0001);
        send_item(CMD_START, -16'sh0001);
        send_item(CMD_MEAS, 16'sh7FFF);
        send_item(CMD_MEAS, -16'sh8000);
        send_item(CMD_MEAS, 16'sh5555);
        send_item(CMD_MEAS, -16'sh5556);
        send_item(CMD_START, 16'sh7FFF);
        send_item(CMD_MEAS, -16'sh8000);
        send_item(CMD_MEAS, -16'sh8000);
        send_item(CMD_MEAS, -16'sh7FFF);
        settle_idle();

        while (outs_seen < TARGET_RESULTS) begin
            settle_idle();
            kind = $urandom_range(0, 5);
            case (kind)
                0:       begin reg_write(REG_INIT_I, 8'd0);   reg_write(REG_INIT_Q, 8'd0);   end
                1:       begin reg_write(REG_INIT_I, 8'd255); reg_write(REG_INIT_Q, 8'd255); end
                2:       begin reg_write(REG_INIT_I, 8'd0);   reg_write(REG_INIT_Q, 8'd255); end
                default: begin
                    reg_write(REG_INIT_I, CFG_W'(pick_code()));
                    reg_write(REG_INIT_Q, CFG_W'(pick_code()));
                end
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                closed_search(pick_code(), pick_code());
            end else if (kind < 9) begin
                open_burst($urandom_range(1, 260));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(logic'($urandom_range(0, 1)), LEVEL_W'($urandom));
            end
        end

        in_if.valid <= 1'b0;
        k = 0;
        do begin
            @(posedge i_clk);
            k++;
        end while (pending_count != 0 && k < 20000);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
design/iqcf_pkg.sv
design/iqcf_if.sv
design/iq_offset_coarse_fine_search.sv
test/iqcf_search_checker.sv
test/testbench.sv
